// ----- rtl/atc_pkg.sv -----
// Shared types and constants for the alarm table clock.
// Used by atc_core and alarm_table_clock; no other dependencies.
`default_nettype none

package atc_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_CHECK  = 2'd2
  } kind_t;

  // Event codes on the result channel
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_WAKE    = 2'd1;
  localparam logic [1:0] EV_GENERAL = 2'd2;

  // Targets below this wake a process; the rest raise a general alarm
  localparam logic [3:0] PROCESS_COUNT = 4'd10;

  // One alarm slot as stored in the table memory
  typedef struct packed {
    logic        valid;
    logic [31:0] alarm_time;
    logic [31:0] period;
    logic [3:0]  target;
    logic        repeat_flag;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Result of one request, handed from the core to the output register
  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  woken_process;
    logic        table_full;
    logic [31:0] clock_now;
  } res_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/atc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module atc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/atc_core.sv -----
// Sequencer for the alarm table: clock, clearing pass, slot scan and write-back.
// Depends on atc_pkg; drives the ports of one atc_ram instance.
`default_nettype none

module atc_core
  import atc_pkg::*;
#(
  parameter int SLOTS = 512,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = IDX_W + 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request side
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_kind,
  input  wire logic [31:0]       in_start_time,
  input  wire logic [31:0]       in_period,
  input  wire logic [3:0]        in_target,
  input  wire logic              in_repeat_req,
  // result side
  output logic                   res_valid,
  output res_t                   res,
  input  wire logic              res_ready,
  // table memory
  output logic                   ram_we,
  output logic [IDX_W-1:0]       ram_waddr,
  output logic [SLOT_W-1:0]      ram_wdata,
  output logic [IDX_W-1:0]       ram_raddr,
  input  wire logic [SLOT_W-1:0] ram_rdata
);

  state_t state_r, state_nxt;

  logic [31:0]      clock_r, clock_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [31:0]      period_r, period_nxt;
  logic [3:0]       target_r, target_nxt;
  logic             repeat_r, repeat_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             dat_vld_r, dat_vld_nxt;
  logic [IDX_W-1:0] dat_idx_r, dat_idx_nxt;
  res_t             res_r, res_nxt;

  slot_t slot_rd;
  slot_t slot_wr;
  logic  hit;
  logic  last;
  logic  issue;
  logic  clr_done;

  // Decode the slot read back from the table
  assign slot_rd  = slot_t'(ram_rdata);
  assign issue    = (rd_idx_r < CNT_W'(SLOTS));
  assign last     = dat_vld_r && (dat_idx_r == IDX_W'(SLOTS - 1));
  assign clr_done = (rd_idx_r == CNT_W'(SLOTS - 1));

  // Match: a free slot for create, a due alarm for check
  always_comb begin
    hit = 1'b0;
    if (dat_vld_r) begin
      if (kind_r == KIND_CREATE) begin
        hit = !slot_rd.valid;
      end else begin
        hit = slot_rd.valid && (slot_rd.alarm_time == clock_r);
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_CREATE || in_kind == KIND_CHECK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (hit || last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath and memory access
  always_comb begin
    clock_nxt   = clock_r;
    kind_nxt    = kind_r;
    start_nxt   = start_r;
    period_nxt  = period_r;
    target_nxt  = target_r;
    repeat_nxt  = repeat_r;
    rd_idx_nxt  = rd_idx_r;
    dat_vld_nxt = dat_vld_r;
    dat_idx_nxt = dat_idx_r;
    res_nxt     = res_r;
    slot_wr     = slot_rd;
    ram_we      = 1'b0;
    ram_waddr   = dat_idx_r;
    ram_raddr   = rd_idx_r[IDX_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        // Free one slot per cycle after reset
        slot_wr    = '0;
        ram_we     = 1'b1;
        ram_waddr  = rd_idx_r[IDX_W-1:0];
        rd_idx_nxt = clr_done ? '0 : rd_idx_r + CNT_W'(1);
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          start_nxt   = in_start_time;
          period_nxt  = in_period;
          target_nxt  = in_target;
          repeat_nxt  = in_repeat_req;
          rd_idx_nxt  = '0;
          dat_vld_nxt = 1'b0;
          res_nxt.event_res     = EV_NONE;
          res_nxt.woken_process = 4'd0;
          res_nxt.table_full    = 1'b0;
          res_nxt.clock_now     = clock_r;
          if (in_kind == KIND_TICK) begin
            clock_nxt         = clock_r + 32'd1;
            res_nxt.clock_now = clock_r + 32'd1;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          // Modify the matching slot and write it back
          ram_we = 1'b1;
          if (kind_r == KIND_CREATE) begin
            slot_wr.valid       = 1'b1;
            slot_wr.alarm_time  = start_r;
            slot_wr.period      = period_r;
            slot_wr.target      = target_r;
            slot_wr.repeat_flag = repeat_r;
          end else if (slot_rd.target < PROCESS_COUNT) begin
            slot_wr.valid         = 1'b0;
            res_nxt.event_res     = EV_WAKE;
            res_nxt.woken_process = slot_rd.target;
          end else begin
            res_nxt.event_res = EV_GENERAL;
            if (slot_rd.repeat_flag) begin
              slot_wr.alarm_time = slot_rd.alarm_time + slot_rd.period;
            end else begin
              slot_wr.valid = 1'b0;
            end
          end
        end else if (last) begin
          // Scan ran off the end without a match
          res_nxt.table_full = (kind_r == KIND_CREATE);
        end else begin
          // Advance the read pointer
          dat_vld_nxt = issue;
          dat_idx_nxt = rd_idx_r[IDX_W-1:0];
          if (issue) rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign ram_wdata = slot_wr;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clock_r   <= 32'd0;
      rd_idx_r  <= '0;
      dat_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clock_r   <= clock_nxt;
      rd_idx_r  <= rd_idx_nxt;
      dat_vld_r <= dat_vld_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    start_r   <= start_nxt;
    period_r  <= period_nxt;
    target_r  <= target_nxt;
    repeat_r  <= repeat_nxt;
    dat_idx_r <= dat_idx_nxt;
    res_r     <= res_nxt;
  end

  // A create or check request always starts a scan
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && in_valid && (in_kind == KIND_CREATE || in_kind == KIND_CHECK)
    |=> state_r == ST_SCAN)
    else $error("create or check did not enter scan");

  // The clock moves only on an accepted tick
  a_clock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |=> $stable(clock_r))
    else $error("clock changed outside a tick");

  // A wake names a real process
  a_wake_id: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.event_res == EV_WAKE |-> res.woken_process < PROCESS_COUNT)
    else $error("wake with out-of-range process");

  // Full is only reported for a create
  a_full_create: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.table_full |-> kind_r == KIND_CREATE && res.event_res == EV_NONE)
    else $error("table full on a non-create request");

  // Scan writes only where the matched slot was read
  a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && ram_we |-> dat_vld_r && ram_waddr == dat_idx_r)
    else $error("scan write without a matching read");

endmodule

`default_nettype wire

// ----- rtl/alarm_table_clock.sv -----
// Top level of the alarm table clock: table memory, sequencer and output register.
// Depends on atc_pkg, atc_ram and atc_core.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_kind, in_start_time,    | request in
//          | in_period, in_target, in_repeat_req            |
//  out     | out_valid, out_stall, out_event_res,           | result out
//          | out_woken_process, out_table_full, out_clock_now|
//
// A tick or unused kind goes straight to the result; a create or check scans the table one slot per
// cycle through the memory read port, until a match or the last slot.
// After reset a clearing pass frees all SLOTS slots, one per cycle; in_stall stays high.
// One request is in work at a time; a finished result waits in the output register
// while the next request is accepted, and out_stall holds it.
`default_nettype none

module alarm_table_clock
  import atc_pkg::*;
#(
  parameter int SLOTS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_start_time,
  input  wire logic [31:0] in_period,
  input  wire logic [3:0]  in_target,
  input  wire logic        in_repeat_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_event_res,
  output logic [3:0]       out_woken_process,
  output logic             out_table_full,
  output logic [31:0]      out_clock_now
);

  localparam int IDX_W = $clog2(SLOTS);

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  logic res_valid;
  res_t res;
  logic res_ready;

  logic out_valid_r;
  res_t out_res_r;

  atc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  atc_core #(
    .SLOTS (SLOTS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_start_time (in_start_time),
    .in_period     (in_period),
    .in_target     (in_target),
    .in_repeat_req (in_repeat_req),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // Take a new result when the output register is empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Hold the result payload while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_res_r.event_res;
  assign out_woken_process = out_res_r.woken_process;
  assign out_table_full    = out_res_r.table_full;
  assign out_clock_now     = out_res_r.clock_now;

endmodule

`default_nettype wire
